/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tsve_pkg.sv */
`default_nettype none

package tsve_pkg;

    localparam int COUNT_DIGITS_DEFAULT = 10;
    localparam int PAD_WIDTH            = 6;
    localparam int RESULT_CAP           = 15;
    localparam int TAIL_DEPTH           = 4;

    localparam logic [7:0] ASCII_TAB    = 8'h09;
    localparam logic [7:0] ASCII_NL     = 8'h0A;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_DOLLAR = 8'h24;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_QUEST  = 8'h3F;
    localparam logic [7:0] ASCII_UPPER_I = 8'h49;
    localparam logic [7:0] ASCII_UPPER_M = 8'h4D;
    localparam logic [7:0] ASCII_CARET  = 8'h5E;
    localparam logic [7:0] ASCII_DEL    = 8'h7F;
    localparam logic [7:0] ESC_NL       = 8'h8A;
    localparam logic [6:0] CTRL_BIT     = 7'h40;
    localparam logic [6:0] FIRST_PRINT  = 7'h20;

    typedef enum logic [2:0] {
        CFG_NUMBER_MODE      = 3'd0,
        CFG_SQUEEZE_BLANK    = 3'd1,
        CFG_SHOW_ENDS        = 3'd2,
        CFG_SHOW_TABS        = 3'd3,
        CFG_SHOW_NONPRINTING = 3'd4
    } cfg_index_t;

endpackage

`default_nettype wire

/* rtl/core/text_stream_visible_escape.sv */
// Byte-serial text filter with the behavior of the cat -benstuv options in the C locale. Each
// input transaction carries one text byte and a new-file flag, and expands into 1 to 15 output
// transactions: an optional right-aligned line number and tab, an optional dollar sign before a
// newline, and the byte itself in caret or M- notation when enabled. A squeezed blank line gives
// exactly one output transaction with tuser set and tlast set. The block takes one input byte per
// cycle while the output does not stall and every byte expands to a single output byte; an
// input that expands to more bytes holds the single output byte lane until its last byte is
// taken, and the next input can be taken in that same cycle. The user must write configuration
// through cfg_we, cfg_addr, cfg_wdata only while the stream is idle; the block does not check it.
`default_nettype none

`include "assert_macros.svh"

module text_stream_visible_escape
#(
    parameter int COUNT_DIGITS = tsve_pkg::COUNT_DIGITS_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_addr,
    input  wire logic [1:0] cfg_wdata,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_axis_tuser,   // [0] new_file

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // last
    output logic [0:0]      m_axis_tuser    // [0] none
);

    import tsve_pkg::*;

    localparam int DIG_W  = $clog2(COUNT_DIGITS);
    localparam int LEN_W  = $clog2(COUNT_DIGITS + 2);
    localparam int POS_W  = $clog2(RESULT_CAP);
    localparam int IDX_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int TOT_W  = IDX_W + 1;

    logic [1:0] number_mode_reg;
    logic       squeeze_blank_reg;
    logic       show_ends_reg;
    logic       show_tabs_reg;
    logic       show_nonprinting_reg;

    logic                          at_line_start_reg;
    logic                          at_line_start_next;
    logic                          squeezing_reg;
    logic                          squeezing_next;
    logic [COUNT_DIGITS-1:0][3:0]  count_reg;
    logic [COUNT_DIGITS-1:0][3:0]  count_next;

    logic                          busy_reg;
    logic                          none_reg;
    logic                          none_next;
    logic [COUNT_DIGITS-1:0][3:0]  digits_reg;
    logic [LEN_W-1:0]              sig_reg;
    logic [LEN_W-1:0]              sig_next;
    logic [LEN_W-1:0]              nlen_reg;
    logic [LEN_W-1:0]              nlen_next;
    logic [TAIL_DEPTH-1:0][7:0]    tail_reg;
    logic [TAIL_DEPTH-1:0][7:0]    tail_next;
    logic [POS_W-1:0]              last_reg;
    logic [POS_W-1:0]              last_next;
    logic [POS_W-1:0]              pos_reg;

    logic                          in_fire;
    logic                          out_fire;
    logic                          at_last;

    logic                          eff_line_start;
    logic                          eff_squeezing;
    logic [COUNT_DIGITS-1:0][3:0]  eff_count;
    logic [COUNT_DIGITS-1:0][3:0]  inc_count;
    logic [7:0]                    data_byte;
    logic                          is_nl;
    logic                          squeezed;
    logic                          number_on;
    logic [2:0]                    tail_len;
    logic [1:0]                    tail_pos;
    logic [6:0]                    low7;
    logic [TOT_W-1:0]              total;
    logic                          carry;

    logic [IDX_W-1:0]              pos_ext;
    logic [IDX_W-1:0]              nlen_ext;
    logic [IDX_W-1:0]              digit_idx;
    logic [IDX_W-1:0]              tail_idx;
    logic [7:0]                    out_byte;

    assign at_last       = (pos_reg == last_reg);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !busy_reg || (m_axis_tready && at_last);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg      <= '0;
            squeeze_blank_reg    <= 1'b0;
            show_ends_reg        <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_NUMBER_MODE:      number_mode_reg      <= cfg_wdata;
                CFG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_wdata[0];
                CFG_SHOW_ENDS:        show_ends_reg        <= cfg_wdata[0];
                CFG_SHOW_TABS:        show_tabs_reg        <= cfg_wdata[0];
                CFG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    // Line state as seen by this byte, then its update.
    always_comb
    begin
        data_byte      = s_axis_tdata;
        eff_line_start = s_axis_tuser[0] ? 1'b1 : at_line_start_reg;
        eff_squeezing  = s_axis_tuser[0] ? 1'b0 : squeezing_reg;
        eff_count      = s_axis_tuser[0] ? '0 : count_reg;
        is_nl          = (data_byte == ASCII_NL);

        squeezed = eff_line_start && squeeze_blank_reg && is_nl && eff_squeezing;

        squeezing_next = eff_squeezing;
        if (eff_line_start && squeeze_blank_reg)
        begin
            squeezing_next = is_nl;
        end

        number_on = eff_line_start && !squeezed && (number_mode_reg != 2'd0)
                    && (!number_mode_reg[1] || !is_nl);

        carry     = 1'b1;
        inc_count = eff_count;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            if (carry)
            begin
                if (eff_count[i] >= 4'd9)
                begin
                    inc_count[i] = 4'd0;
                end
                else
                begin
                    inc_count[i] = eff_count[i] + 4'd1;
                    carry        = 1'b0;
                end
            end
        end
        count_next = number_on ? inc_count : eff_count;

        if (squeezed)
        begin
            at_line_start_next = eff_line_start;
        end
        else
        begin
            at_line_start_next = is_nl || (show_nonprinting_reg && (data_byte == ESC_NL));
        end
    end

    // Number prefix length and the escaped byte sequence.
    always_comb
    begin
        sig_next = LEN_W'(1);
        for (int i = 1; i < COUNT_DIGITS; i++)
        begin
            if (count_next[i] != 4'd0)
            begin
                sig_next = LEN_W'(i + 1);
            end
        end

        if (!number_on)
        begin
            nlen_next = '0;
        end
        else if (sig_next > LEN_W'(PAD_WIDTH))
        begin
            nlen_next = sig_next + LEN_W'(1);
        end
        else
        begin
            nlen_next = LEN_W'(PAD_WIDTH + 1);
        end

        low7      = data_byte[6:0];
        tail_next = '0;
        tail_len  = 3'd1;
        tail_pos  = 2'd0;
        tail_next[0] = data_byte;
        if (is_nl)
        begin
            if (show_ends_reg)
            begin
                tail_next[0] = ASCII_DOLLAR;
                tail_next[1] = ASCII_NL;
                tail_len     = 3'd2;
            end
        end
        else if (data_byte == ASCII_TAB)
        begin
            if (show_tabs_reg)
            begin
                tail_next[0] = ASCII_CARET;
                tail_next[1] = ASCII_UPPER_I;
                tail_len     = 3'd2;
            end
        end
        else if (show_nonprinting_reg)
        begin
            if (data_byte[7])
            begin
                tail_next[0] = ASCII_UPPER_M;
                tail_next[1] = ASCII_MINUS;
                tail_pos     = 2'd2;
            end
            if (low7 < FIRST_PRINT || {1'b0, low7} == ASCII_DEL)
            begin
                tail_next[tail_pos]        = ASCII_CARET;
                tail_next[tail_pos + 2'd1] = ({1'b0, low7} == ASCII_DEL) ? ASCII_QUEST
                                                                          : {1'b0, low7 | CTRL_BIT};
                tail_len = {1'b0, tail_pos} + 3'd2;
            end
            else
            begin
                tail_next[tail_pos] = {1'b0, low7};
                tail_len            = {1'b0, tail_pos} + 3'd1;
            end
        end

        none_next = squeezed;
        total     = TOT_W'(nlen_next) + TOT_W'(tail_len);
        if (squeezed)
        begin
            last_next = '0;
        end
        else if (total > TOT_W'(RESULT_CAP))
        begin
            last_next = POS_W'(RESULT_CAP - 1);
        end
        else
        begin
            last_next = POS_W'(total - TOT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            squeezing_reg     <= 1'b0;
            count_reg         <= '0;
            busy_reg          <= 1'b0;
            pos_reg           <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                at_line_start_reg <= at_line_start_next;
                squeezing_reg     <= squeezing_next;
                count_reg         <= count_next;
                busy_reg          <= 1'b1;
                pos_reg           <= '0;
            end
            else if (out_fire)
            begin
                if (at_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            none_reg   <= none_next;
            digits_reg <= count_next;
            sig_reg    <= sig_next;
            nlen_reg   <= nlen_next;
            tail_reg   <= tail_next;
            last_reg   <= last_next;
        end
    end

    // Output byte at the current position of the transaction run.
    always_comb
    begin
        pos_ext   = IDX_W'(pos_reg);
        nlen_ext  = IDX_W'(nlen_reg);
        digit_idx = nlen_ext - IDX_W'(2) - pos_ext;
        tail_idx  = pos_ext - nlen_ext;
        if (none_reg)
        begin
            out_byte = '0;
        end
        else if (pos_ext < nlen_ext)
        begin
            if (pos_ext == nlen_ext - IDX_W'(1))
            begin
                out_byte = ASCII_TAB;
            end
            else if (digit_idx >= IDX_W'(sig_reg))
            begin
                out_byte = ASCII_SPACE;
            end
            else
            begin
                out_byte = ASCII_ZERO + {4'd0, digits_reg[digit_idx[DIG_W-1:0]]};
            end
        end
        else
        begin
            out_byte = tail_reg[tail_idx[1:0]];
        end
    end

    assign m_axis_tvalid   = busy_reg;
    assign m_axis_tdata    = out_byte;
    assign m_axis_tlast    = at_last;
    assign m_axis_tuser[0] = none_reg;

    `ASSERT_CLK(a_squeeze_single, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast,
        "A squeezed byte must produce a single final transaction.")
    `ASSERT_CLK(a_take_on_last, (in_fire && busy_reg) |-> (m_axis_tready && m_axis_tlast),
        "A new byte was taken before the previous run finished.")
    `ASSERT_CLK(a_pos_in_range, busy_reg |-> (pos_reg <= last_reg),
        "Output position ran past the final transaction.")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;

    import tsve_pkg::*;

    localparam int NUM_DIGITS     = COUNT_DIGITS_DEFAULT;
    localparam int QUIET_LIMIT    = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int PRINT_CAP      = 40;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze;
        logic       ends;
        logic       tabs;
        logic       nonprint;
    } filter_cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       squeezed;
    } filter_result_t;

    typedef struct {
        filter_cfg_t cfg;
        logic [7:0]  data;
        logic        nf;
        string       lit;
        logic        gone;
    } stim_row_t;

    localparam filter_cfg_t PLAIN     = '0;
    localparam filter_cfg_t ALL_ON    = '{number_mode: 2'd1, squeeze: 1'b1, ends: 1'b1,
                                          tabs: 1'b1, nonprint: 1'b1};
    localparam filter_cfg_t NONBLANK  = '{number_mode: 2'd2, default: 1'b0};
    localparam filter_cfg_t MODE3     = '{number_mode: 2'd3, default: 1'b0};
    localparam filter_cfg_t EVERY     = '{number_mode: 2'd1, default: 1'b0};
    localparam filter_cfg_t MODE3_ALL = '{number_mode: 2'd3, squeeze: 1'b1, ends: 1'b1,
                                          tabs: 1'b1, nonprint: 1'b1};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [1:0] cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;

    filter_cfg_t    cur_cfg = '0;
    logic           at_bol = 1'b1;
    logic           squeezing = 1'b0;
    logic [3:0]     line_digits [NUM_DIGITS] = '{default: 4'd0};
    filter_result_t rendered_q[$];
    stim_row_t      plan[$];
    int             mismatches = 0;
    int             quiet_cycles = 0;
    int             hold_asks = 0;
    int             hold_seen = 0;
    int             hold_left = 0;
    int             stall_left = 0;
    logic           rx_calm = 1'b0;
    logic           tx_idle = 1'b1;

    text_stream_visible_escape #(
        .COUNT_DIGITS (NUM_DIGITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    // Works out the output bytes of one input byte and advances the line state.
    function automatic void render_byte(input logic [7:0] raw, input logic nf);
        logic [7:0] ch;
        logic [7:0] seq[$];
        logic       carry;
        int         sig;
        int         span;
        int         i;
        ch = raw;
        sig = 1;
        if (nf)
        begin
            at_bol = 1'b1;
            squeezing = 1'b0;
            for (i = 0; i < NUM_DIGITS; i++)
            begin
                line_digits[i] = 4'd0;
            end
        end
        if (at_bol)
        begin
            if (cur_cfg.squeeze)
            begin
                if (ch == ASCII_NL)
                begin
                    if (squeezing)
                    begin
                        rendered_q.push_back('{out_byte: 8'h00, last: 1'b1, squeezed: 1'b1});
                        return;
                    end
                    squeezing = 1'b1;
                end
                else
                begin
                    squeezing = 1'b0;
                end
            end
            if (cur_cfg.number_mode != 2'd0 && (!cur_cfg.number_mode[1] || ch != ASCII_NL))
            begin
                carry = 1'b1;
                for (i = 0; i < NUM_DIGITS; i++)
                begin
                    if (carry)
                    begin
                        if (line_digits[i] >= 4'd9)
                        begin
                            line_digits[i] = 4'd0;
                        end
                        else
                        begin
                            line_digits[i] = line_digits[i] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
                for (i = NUM_DIGITS - 1; i > 0; i--)
                begin
                    if (line_digits[i] != 4'd0 && sig == 1)
                    begin
                        sig = i + 1;
                    end
                end
                span = (sig > PAD_WIDTH) ? sig : PAD_WIDTH;
                for (i = span - 1; i >= 0; i--)
                begin
                    seq.push_back((i >= sig) ? ASCII_SPACE : ASCII_ZERO + line_digits[i]);
                end
                seq.push_back(ASCII_TAB);
            end
        end
        if (ch == ASCII_NL)
        begin
            if (cur_cfg.ends)
            begin
                seq.push_back(ASCII_DOLLAR);
            end
            seq.push_back(ch);
        end
        else if (ch == ASCII_TAB)
        begin
            if (cur_cfg.tabs)
            begin
                seq.push_back(ASCII_CARET);
                seq.push_back(ASCII_UPPER_I);
            end
            else
            begin
                seq.push_back(ch);
            end
        end
        else if (cur_cfg.nonprint)
        begin
            if (ch[7])
            begin
                seq.push_back(ASCII_UPPER_M);
                seq.push_back(ASCII_MINUS);
                ch[7] = 1'b0;
            end
            if (ch < {1'b0, FIRST_PRINT} || ch == ASCII_DEL)
            begin
                seq.push_back(ASCII_CARET);
                seq.push_back((ch == ASCII_DEL) ? ASCII_QUEST : (ch | {1'b0, CTRL_BIT}));
            end
            else
            begin
                seq.push_back(ch);
            end
        end
        else
        begin
            seq.push_back(ch);
        end
        at_bol = (ch == ASCII_NL);
        span = (seq.size() > RESULT_CAP) ? RESULT_CAP : seq.size();
        for (i = 0; i < span; i++)
        begin
            rendered_q.push_back('{out_byte: seq[i], last: (i == span - 1), squeezed: 1'b0});
        end
    endfunction

    function automatic void add_row(input filter_cfg_t cfg, input logic [7:0] data,
                                    input logic nf, input string lit, input logic gone);
        stim_row_t row;
        row.cfg = cfg;
        row.data = data;
        row.nf = nf;
        row.lit = lit;
        row.gone = gone;
        plan.push_back(row);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_byte(input logic [7:0] data, input logic nf, input string lit,
                              input logic gone);
        int gap;
        int mark;
        int i;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        mark = rendered_q.size();
        render_byte(data, nf);
        if (gone || lit.len() != 0)
        begin
            while (rendered_q.size() > mark)
            begin
                void'(rendered_q.pop_back());
            end
            if (gone)
            begin
                rendered_q.push_back('{out_byte: 8'h00, last: 1'b1, squeezed: 1'b1});
            end
            else
            begin
                for (i = 0; i < lit.len(); i++)
                begin
                    rendered_q.push_back('{out_byte: lit[i], last: (i == lit.len() - 1),
                                           squeezed: 1'b0});
                end
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= nf;
        do
        begin
            @(posedge clk);
        end
        while (s_axis_tready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (rendered_q.size() != 0);
    endtask

    task automatic load_filter_cfg(input filter_cfg_t cfg);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_NUMBER_MODE;
        cfg_wdata <= cfg.number_mode;
        @(negedge clk);
        cfg_addr <= CFG_SQUEEZE_BLANK;
        cfg_wdata <= {1'b0, cfg.squeeze};
        @(negedge clk);
        cfg_addr <= CFG_SHOW_ENDS;
        cfg_wdata <= {1'b0, cfg.ends};
        @(negedge clk);
        cfg_addr <= CFG_SHOW_TABS;
        cfg_wdata <= {1'b0, cfg.tabs};
        @(negedge clk);
        cfg_addr <= CFG_SHOW_NONPRINTING;
        cfg_wdata <= {1'b0, cfg.nonprint};
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_cfg = cfg;
    endtask

    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (rendered_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected output transaction %h last %b none %b",
                                       m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end
            else
            begin
                want = rendered_q.pop_front();
                if (m_axis_tdata !== want.out_byte || m_axis_tlast !== want.last ||
                    m_axis_tuser[0] !== want.squeezed)
                begin
                    log_mismatch($sformatf("got %h/%b/%b, expected %h/%b/%b",
                                           m_axis_tdata, m_axis_tlast, m_axis_tuser,
                                           want.out_byte, want.last, want.squeezed));
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        filter_cfg_t cfg;
        logic [7:0]  data;
        logic        nf;
        logic        cfg_loaded;
        int          phase;
        int          k;
        int          pick;

        cfg_loaded = 1'b0;
        add_row(PLAIN, "A", 1'b0, "A", 1'b0);
        add_row(PLAIN, 8'hFF, 1'b0, "", 1'b0);
        add_row(PLAIN, 8'h00, 1'b1, "", 1'b0);
        add_row(ALL_ON, ASCII_NL, 1'b1, "     1\t$\n", 1'b0);
        add_row(ALL_ON, ASCII_NL, 1'b0, "", 1'b1);
        add_row(ALL_ON, ASCII_NL, 1'b0, "", 1'b1);
        add_row(ALL_ON, "x", 1'b0, "     2\tx", 1'b0);
        add_row(ALL_ON, ASCII_TAB, 1'b0, "^I", 1'b0);
        add_row(ALL_ON, 8'h00, 1'b0, "^@", 1'b0);
        add_row(ALL_ON, ASCII_DEL, 1'b0, "^?", 1'b0);
        add_row(ALL_ON, 8'hFF, 1'b0, "M-^?", 1'b0);
        add_row(ALL_ON, 8'h80, 1'b0, "M-^@", 1'b0);
        add_row(ALL_ON, 8'hA0, 1'b0, "M- ", 1'b0);
        add_row(ALL_ON, ESC_NL, 1'b0, "M-^J", 1'b0);
        add_row(ALL_ON, "y", 1'b0, "     3\ty", 1'b0);
        add_row(ALL_ON, ASCII_NL, 1'b0, "$\n", 1'b0);
        add_row(ALL_ON, 8'h9B, 1'b1, "     1\tM-^[", 1'b0);
        add_row(NONBLANK, ASCII_NL, 1'b1, "\n", 1'b0);
        add_row(NONBLANK, ASCII_TAB, 1'b0, "     1\t\t", 1'b0);
        add_row(NONBLANK, 8'h01, 1'b0, "", 1'b0);
        add_row(MODE3, ASCII_NL, 1'b1, "\n", 1'b0);
        add_row(MODE3, "z", 1'b0, "     1\tz", 1'b0);
        add_row(EVERY, ASCII_NL, 1'b1, "     1\t\n", 1'b0);
        add_row(EVERY, ASCII_NL, 1'b0, "     2\t\n", 1'b0);
        add_row(EVERY, ASCII_DEL, 1'b0, "", 1'b0);
        add_row(EVERY, "q", 1'b0, "q", 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[r])
        begin
            if (!cfg_loaded || plan[r].cfg != cur_cfg)
            begin
                load_filter_cfg(plan[r].cfg);
                cfg_loaded = 1'b1;
            end
            offer_byte(plan[r].data, plan[r].nf, plan[r].lit, plan[r].gone);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                3:       cfg = MODE3_ALL;
                6:       cfg = PLAIN;
                default: cfg = filter_cfg_t'(6'($urandom_range(0, 63)));
            endcase
            if (phase == PHASES - 1)
            begin
                rx_calm <= 1'b1;
                tx_idle = 1'b0;
            end
            load_filter_cfg(cfg);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == 2 && k == 5)
                begin
                    hold_asks <= hold_asks + 1;
                end
                if (phase == 5 && k == 20)
                begin
                    wait_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    data = 8'($urandom_range(0, 255));
                end
                else if (pick < 36)
                begin
                    data = ASCII_NL;
                end
                else if (pick < 42)
                begin
                    data = ASCII_TAB;
                end
                else if (pick < 46)
                begin
                    data = 8'($urandom_range(0, 31));
                end
                else if (pick < 52)
                begin
                    data = 8'($urandom_range(127, 255));
                end
                else
                begin
                    data = 8'($urandom_range(32, 126));
                end
                nf = ($urandom_range(0, 39) == 0);
                offer_byte(data, nf, "", 1'b0);
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (rendered_q.size() != 0)
        begin
            log_mismatch($sformatf("%0d output transactions never arrived", rendered_q.size()));
        end
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/tsve_pkg.sv
rtl/core/text_stream_visible_escape.sv
verif/tb_top.sv
